// ----- rtl/mnas_pkg.sv -----
`timescale 1ns / 1ps
// types, codes and reset constants shared by the note sequencer modules
// no dependencies
package mnas_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned NOTE_W     = 7;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned MS16_W     = 16;

   localparam logic [TIME_W-1:0] HOLD_CEILING_RST     = 32'd60000;
   localparam logic [MS16_W-1:0] POSITION_DELAY_RST   = 16'd50;
   localparam logic [MS16_W-1:0] MIN_NOTE_RST         = 16'd30;
   localparam logic [MS16_W-1:0] VALVE_KEEP_GAP_RST   = 16'd50;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_POS  = 2'd1,
      MODE_PLAY = 2'd2,
      MODE_STOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_NOTE_ON  = 2'd1,
      CMD_NOTE_OFF = 2'd2,
      CMD_PANIC    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      VALVE_NONE  = 2'd0,
      VALVE_OPEN  = 2'd1,
      VALVE_CLOSE = 2'd2
   } valve_type;

   typedef enum logic [1:0] {
      AIR_NONE = 2'd0,
      AIR_SET  = 2'd1,
      AIR_REST = 2'd2,
      AIR_MIN  = 2'd3
   } air_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_DELAY = 3'd0,
      CSR_MIN_NOTE       = 3'd1,
      CSR_VALVE_KEEP_GAP = 3'd2,
      CSR_HOLD_CEILING   = 3'd3,
      CSR_HAS_VALVE      = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [MS16_W-1:0] position_delay_ms;
      logic [MS16_W-1:0] min_note_ms;
      logic [MS16_W-1:0] valve_keep_gap_ms;
      logic [TIME_W-1:0] hold_ceiling_ms;
      logic              has_valve;
   } cfg_type;

   typedef struct packed {
      cmd_type           command;
      logic [NOTE_W-1:0] note;
      logic [NOTE_W-1:0] velocity;
      logic [TIME_W-1:0] event_time;
      logic              sound_allowed;
      logic              next_is_note_on;
      logic [TIME_W-1:0] next_time;
   } req_type;

   typedef struct packed {
      mode_type          mode;
      logic [NOTE_W-1:0] cur_note;
      logic [NOTE_W-1:0] cur_velocity;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] state_start_ms;
      logic [TIME_W-1:0] scheduled_ms;
      logic [TIME_W-1:0] sound_start_ms;
      logic              pending_stop;
   } seq_state_type;

   typedef struct packed {
      mode_type          state_now;
      logic              finger_write;
      valve_type         valve_action;
      air_type           air_action;
      logic [NOTE_W-1:0] out_note;
      logic [NOTE_W-1:0] out_velocity;
      logic              note_commanded;
      logic              note_released;
      logic              clear_queue;
   } rsp_type;

endpackage

// ----- rtl/mono_note_actuator_sequencer_core.sv -----
`timescale 1ns / 1ps
// top level of the monophonic note sequencer for a wind-instrument actuator set
// depends on mnas_pkg, mnas_step and mnas_rsp_fifo
//
// The sequencer takes one item per transfer (a 1 ms tick, a note-on, a note-off
// or a panic stop) and returns exactly one result transfer per item carrying
// the finger, valve and airflow commands plus the mode after the item. Items
// are registered on entry, handled by the combinational step logic, and the
// result is registered into a two-entry output buffer that drives rsp_valid; a
// new request is taken every cycle as long as the output buffer has room, so
// the sustained rate is one item per clock. req_stall rises only when the
// entered item cannot move into a full output buffer that is itself stalled.
// Timestamps compare with 32-bit wrap.
// Registers written through the csr port take effect for the next item handled;
// write them only while no result is outstanding.
module mono_note_actuator_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [mnas_pkg::NOTE_W-1:0]         req_note,
   input  logic [mnas_pkg::NOTE_W-1:0]         req_velocity,
   input  logic [mnas_pkg::TIME_W-1:0]         req_event_time,
   input  logic                                req_sound_allowed,
   input  logic                                req_next_is_note_on,
   input  logic [mnas_pkg::TIME_W-1:0]         req_next_time,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_state_now,
   output logic                                rsp_finger_write,
   output logic [1:0]                          rsp_valve_action,
   output logic [1:0]                          rsp_air_action,
   output logic [mnas_pkg::NOTE_W-1:0]         rsp_out_note,
   output logic [mnas_pkg::NOTE_W-1:0]         rsp_out_velocity,
   output logic                                rsp_note_commanded,
   output logic                                rsp_note_released,
   output logic                                rsp_clear_queue,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [mnas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mnas_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mnas_pkg::*;

   // configuration registers
   cfg_type       cfg_ff;
   cfg_type       cfg_in;

   // input stage
   req_type       req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   logic          req_xfer;

   // sequencer state
   seq_state_type seq_ff;
   seq_state_type seq_next;
   rsp_type       step_rsp;
   rsp_type       buf_rsp;
   logic          buf_can_push;
   logic          advance;

   assign req_xfer  = req_valid && !req_stall;
   // entered item moves into the output buffer whenever there is room
   assign advance   = req_valid_ff && buf_can_push;
   assign req_stall = req_valid_ff && !buf_can_push;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_POSITION_DELAY: cfg_in.position_delay_ms = csr_wdata[MS16_W-1:0];
            CSR_MIN_NOTE:       cfg_in.min_note_ms       = csr_wdata[MS16_W-1:0];
            CSR_VALVE_KEEP_GAP: cfg_in.valve_keep_gap_ms = csr_wdata[MS16_W-1:0];
            CSR_HOLD_CEILING:   cfg_in.hold_ceiling_ms   = csr_wdata[TIME_W-1:0];
            CSR_HAS_VALVE:      cfg_in.has_valve         = csr_wdata[0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   always_comb begin
      if (req_xfer) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_delay_ms <= POSITION_DELAY_RST;
         cfg_ff.min_note_ms       <= MIN_NOTE_RST;
         cfg_ff.valve_keep_gap_ms <= VALVE_KEEP_GAP_RST;
         cfg_ff.hold_ceiling_ms   <= HOLD_CEILING_RST;
         cfg_ff.has_valve         <= 1'b1;
         req_valid_ff             <= 1'b0;
         seq_ff.mode              <= MODE_IDLE;
         seq_ff.cur_note          <= '0;
         seq_ff.cur_velocity      <= '0;
         seq_ff.now_ms            <= '0;
         seq_ff.state_start_ms    <= '0;
         seq_ff.scheduled_ms      <= '0;
         seq_ff.sound_start_ms    <= '0;
         seq_ff.pending_stop      <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         if (advance) begin
            seq_ff <= seq_next;
         end
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff.command         <= cmd_type'(req_command);
         req_ff.note            <= req_note;
         req_ff.velocity        <= req_velocity;
         req_ff.event_time      <= req_event_time;
         req_ff.sound_allowed   <= req_sound_allowed;
         req_ff.next_is_note_on <= req_next_is_note_on;
         req_ff.next_time       <= req_next_time;
      end
   end

   mnas_step u_step (
      .cfg  (cfg_ff),
      .cur  (seq_ff),
      .item (req_ff),
      .nxt  (seq_next),
      .rsp  (step_rsp)
   );

   mnas_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (step_rsp),
      .can_push  (buf_can_push),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (buf_rsp)
   );

   assign rsp_state_now      = buf_rsp.state_now;
   assign rsp_finger_write   = buf_rsp.finger_write;
   assign rsp_valve_action   = buf_rsp.valve_action;
   assign rsp_air_action     = buf_rsp.air_action;
   assign rsp_out_note       = buf_rsp.out_note;
   assign rsp_out_velocity   = buf_rsp.out_velocity;
   assign rsp_note_commanded = buf_rsp.note_commanded;
   assign rsp_note_released  = buf_rsp.note_released;
   assign rsp_clear_queue    = buf_rsp.clear_queue;

endmodule

// ----- rtl/mnas_step.sv -----
`timescale 1ns / 1ps
// next-state and command logic for one sequencer item
// depends on mnas_pkg
module mnas_step (
   input  mnas_pkg::cfg_type       cfg,
   input  mnas_pkg::seq_state_type cur,
   input  mnas_pkg::req_type       item,
   output mnas_pkg::seq_state_type nxt,
   output mnas_pkg::rsp_type       rsp
);
   import mnas_pkg::*;

   logic [TIME_W-1:0] now_eff;
   logic [TIME_W-1:0] pos_elapsed;
   logic [TIME_W-1:0] played;
   logic [TIME_W-1:0] next_gap;
   logic [TIME_W-1:0] ev_lead;
   logic              pos_done;
   logic              played_min;
   logic              played_ceiling;
   logic              near_next;
   logic              keep_valve;
   logic              ev_ahead;
   logic              finger;
   logic              commanded;
   logic              released;
   logic              clear_q;
   valve_type         valve;
   air_type           air;

   // tick advances time before any elapsed check
   assign now_eff = (item.command == CMD_TICK) ? cur.now_ms + 32'd1 : cur.now_ms;

   assign pos_elapsed    = now_eff - cur.state_start_ms;
   assign pos_done       = pos_elapsed >= {16'd0, cfg.position_delay_ms};
   assign played         = now_eff - cur.sound_start_ms;
   assign played_min     = played >= {16'd0, cfg.min_note_ms};
   assign played_ceiling = played >= cfg.hold_ceiling_ms;

   // wrapping signed lead of the queue head
   assign next_gap   = item.next_time - now_eff;
   assign near_next  = (next_gap != '0) && !next_gap[TIME_W-1] &&
                       (next_gap < {16'd0, cfg.valve_keep_gap_ms});
   assign keep_valve = cfg.has_valve && item.next_is_note_on && near_next;

   assign ev_lead  = item.event_time - cur.scheduled_ms;
   assign ev_ahead = (ev_lead != '0) && !ev_lead[TIME_W-1];

   always_comb begin
      nxt       = cur;
      nxt.now_ms = now_eff;
      finger    = 1'b0;
      commanded = 1'b0;
      released  = 1'b0;
      clear_q   = 1'b0;
      valve     = VALVE_NONE;
      air       = AIR_NONE;

      case (item.command)
         CMD_TICK: begin
            case (cur.mode)
               MODE_POS: begin
                  if (pos_done) begin
                     air                = AIR_SET;
                     valve              = item.sound_allowed ? VALVE_OPEN : VALVE_CLOSE;
                     nxt.sound_start_ms = now_eff;
                     nxt.mode           = MODE_PLAY;
                     nxt.state_start_ms = now_eff;
                  end
               end
               MODE_PLAY: begin
                  if (cur.pending_stop && played_min) begin
                     nxt.pending_stop = 1'b0;
                     released         = 1'b1;
                     if (keep_valve) begin
                        air = AIR_MIN;
                     end else begin
                        valve = VALVE_CLOSE;
                        air   = AIR_REST;
                     end
                     nxt.mode           = MODE_STOP;
                     nxt.state_start_ms = now_eff;
                  end else if (played_ceiling) begin
                     // forced complete stop
                     nxt.cur_note       = '0;
                     nxt.cur_velocity   = '0;
                     nxt.pending_stop   = 1'b0;
                     clear_q            = 1'b1;
                     valve              = VALVE_CLOSE;
                     air                = AIR_REST;
                     released           = 1'b1;
                     nxt.mode           = MODE_IDLE;
                     nxt.state_start_ms = now_eff;
                  end
               end
               MODE_STOP: begin
                  nxt.mode           = MODE_IDLE;
                  nxt.state_start_ms = now_eff;
               end
               default: begin
               end
            endcase
         end
         CMD_NOTE_ON: begin
            nxt.pending_stop = 1'b0;
            if (cur.mode != MODE_IDLE) begin
               released = 1'b1;
               if (keep_valve) begin
                  air = AIR_MIN;
               end else begin
                  valve = VALVE_CLOSE;
                  air   = AIR_REST;
               end
            end
            nxt.cur_note       = item.note;
            nxt.cur_velocity   = item.velocity;
            nxt.scheduled_ms   = item.event_time;
            finger             = 1'b1;
            commanded          = 1'b1;
            nxt.mode           = MODE_POS;
            nxt.state_start_ms = now_eff;
         end
         CMD_NOTE_OFF: begin
            if (((cur.mode == MODE_PLAY) || (cur.mode == MODE_POS)) &&
                (item.note == cur.cur_note)) begin
               if ((cur.mode == MODE_PLAY) ? !played_min : ev_ahead) begin
                  nxt.pending_stop = 1'b1;
               end else begin
                  released = 1'b1;
                  if (keep_valve) begin
                     air = AIR_MIN;
                  end else begin
                     valve = VALVE_CLOSE;
                     air   = AIR_REST;
                  end
                  nxt.mode           = MODE_STOP;
                  nxt.state_start_ms = now_eff;
               end
            end
         end
         default: begin
            // panic stop
            nxt.cur_note       = '0;
            nxt.cur_velocity   = '0;
            nxt.pending_stop   = 1'b0;
            clear_q            = 1'b1;
            valve              = VALVE_CLOSE;
            air                = AIR_REST;
            released           = (cur.mode != MODE_IDLE);
            nxt.mode           = MODE_IDLE;
            nxt.state_start_ms = now_eff;
         end
      endcase

      rsp.state_now      = nxt.mode;
      rsp.finger_write   = finger;
      rsp.valve_action   = valve;
      rsp.air_action     = air;
      rsp.out_note       = nxt.cur_note;
      rsp.out_velocity   = nxt.cur_velocity;
      rsp.note_commanded = commanded;
      rsp.note_released  = released;
      rsp.clear_queue    = clear_q;
   end

endmodule

// ----- rtl/mnas_rsp_fifo.sv -----
`timescale 1ns / 1ps
// two-entry result buffer between the step logic and the result channel
// depends on mnas_pkg
module mnas_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mnas_pkg::rsp_type push_data,
   output logic              can_push,
   output logic              out_valid,
   input  logic              out_stall,
   output mnas_pkg::rsp_type out_data
);
   import mnas_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // a full buffer still takes a result in the cycle its head leaves
   assign can_push  = (count_ff != 2'd2) || pop;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/mnas_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the note sequencer result channel, bound to the top level
// depends on mnas_pkg and mono_note_actuator_sequencer_core
module mnas_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [1:0]                  rsp_state_now,
   input logic                        rsp_finger_write,
   input logic [1:0]                  rsp_valve_action,
   input logic [1:0]                  rsp_air_action,
   input logic [mnas_pkg::NOTE_W-1:0] rsp_out_note,
   input logic [mnas_pkg::NOTE_W-1:0] rsp_out_velocity,
   input logic                        rsp_note_commanded,
   input logic                        rsp_clear_queue
);
   import mnas_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_state_now) &&
      $stable(rsp_out_note) && $stable(rsp_valve_action))
      else $error("stalled result changed");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // a new note always writes fingers and enters positioning
   a_note_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_note_commanded |->
      rsp_finger_write && (rsp_state_now == MODE_POS))
      else $error("note accepted without positioning");

   // a queue clear comes only with a full stop
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clear_queue |->
      (rsp_state_now == MODE_IDLE) && (rsp_out_note == '0) && (rsp_out_velocity == '0) &&
      (rsp_valve_action == VALVE_CLOSE) && (rsp_air_action == AIR_REST))
      else $error("queue clear without full stop");

endmodule

bind mono_note_actuator_sequencer_core mnas_checker u_mnas_checker (.*);
